[hw/rtl/pid_pkg.sv]
// Shared types, constants and the step program of the PID controller.
// Used by pid_div, pid_ctrl, pid_dp and the top level; depends on nothing.
package pid_pkg;

  localparam int DataW = 32;
  localparam int AccW  = 36;
  localparam int PcW   = 5;
  localparam int CfgIdxW = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_KP   = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_KI   = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_KD   = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_MODE = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_DT   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_TAU  = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_LO   = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_HI   = 4'd7;

  // discretization codes
  localparam logic [2:0] MODE_PURE = 3'd0;
  localparam logic [2:0] MODE_FWD  = 3'd1;
  localparam logic [2:0] MODE_BWD  = 3'd2;
  localparam logic [2:0] MODE_TUST = 3'd3;

  localparam logic signed [DataW-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] Q_TWO   = 32'sh0002_0000;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_REF, SRC_MEAS, SRC_ERR, SRC_ERR1, SRC_U1, SRC_DT, SRC_DTH,
    SRC_TAU, SRC_KP, SRC_KI, SRC_KD, SRC_KD2, SRC_BIGE, SRC_ONE, SRC_TWO,
    SRC_PROD, SRC_ACC, SRC_QUOT, SRC_DEN, SRC_DTT
  } src_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LD, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [1:0] {SUM_HOLD, SUM_CLR, SUM_ADD, SUM_SUB} sum_op_t;
  typedef enum logic [2:0] {DST_NONE, DST_ERR, DST_BIGE, DST_DEN, DST_DTT} dst_t;

  typedef struct packed {
    src_t    a_src;
    src_t    b_src;
    src_t    acc_src;
    acc_op_t acc_op;
    logic    mul_go;
    logic    div_go;
    sum_op_t sum_op;
    dst_t    dst;
    logic    done;
  } ucmd_t;

  typedef struct packed {
    logic  load_in;
    ucmd_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic [2:0] mode;
  } dp_stat_t;

  localparam ucmd_t UCMD_NOP = '{a_src: SRC_ZERO, b_src: SRC_ZERO, acc_src: SRC_ZERO,
                                 acc_op: ACC_HOLD, mul_go: 1'b0, div_go: 1'b0,
                                 sum_op: SUM_HOLD, dst: DST_NONE, done: 1'b0};

  function automatic logic signed [DataW-1:0] sat36(input logic signed [AccW-1:0] v);
    if ((v[AccW-1:DataW-1] == '0) || (v[AccW-1:DataW-1] == '1)) return v[DataW-1:0];
    return v[AccW-1] ? S32_MIN : S32_MAX;
  endfunction

  function automatic logic signed [DataW-1:0] sat48(input logic signed [47:0] v);
    if ((v[47:DataW-1] == '0) || (v[47:DataW-1] == '1)) return v[DataW-1:0];
    return v[47] ? S32_MIN : S32_MAX;
  endfunction

  // Step program: one command per step, selected by mode and step number.
  function automatic ucmd_t ucode(input logic [2:0] mode, input logic [PcW-1:0] pc);
    ucmd_t c;
    c = UCMD_NOP;
    case (pc)
      5'd0: begin c.acc_op = ACC_LD; c.acc_src = SRC_REF; end
      5'd1: begin c.acc_op = ACC_SUB; c.acc_src = SRC_MEAS; end
      5'd2: begin c.dst = DST_ERR; c.sum_op = SUM_CLR; end
      default: begin
        case (mode)
          MODE_PURE: begin
            case (pc)
              5'd3: begin
                c.acc_op = ACC_LD; c.acc_src = SRC_ERR;
                c.mul_go = 1'b1; c.a_src = SRC_KP; c.b_src = SRC_ERR;
              end
              5'd4: begin c.acc_op = ACC_ADD; c.acc_src = SRC_ERR1; c.sum_op = SUM_ADD; end
              5'd5: begin c.dst = DST_BIGE; c.acc_op = ACC_LD; c.acc_src = SRC_ERR; end
              5'd6: begin
                c.acc_op = ACC_SUB; c.acc_src = SRC_ERR1;
                c.mul_go = 1'b1; c.a_src = SRC_KI; c.b_src = SRC_BIGE;
              end
              5'd7: begin
                c.mul_go = 1'b1; c.a_src = SRC_KD; c.b_src = SRC_ACC; c.sum_op = SUM_ADD;
              end
              5'd8: c.sum_op = SUM_ADD;
              default: c.done = 1'b1;
            endcase
          end
          MODE_FWD: begin
            case (pc)
              5'd3: begin c.mul_go = 1'b1; c.a_src = SRC_DT; c.b_src = SRC_ERR1; end
              5'd4: begin
                c.acc_op = ACC_LD; c.acc_src = SRC_PROD;
                c.mul_go = 1'b1; c.a_src = SRC_DT; c.b_src = SRC_TAU;
              end
              5'd5: begin c.acc_op = ACC_ADD; c.acc_src = SRC_U1; end
              5'd6: begin c.dst = DST_BIGE; c.acc_op = ACC_LD; c.acc_src = SRC_PROD; end
              5'd7: begin c.acc_op = ACC_SUB; c.acc_src = SRC_ONE; end
              5'd8: begin c.mul_go = 1'b1; c.a_src = SRC_ACC; c.b_src = SRC_U1; end
              5'd9: begin c.acc_op = ACC_LD; c.acc_src = SRC_ZERO; end
              5'd10: begin
                c.acc_op = ACC_SUB; c.acc_src = SRC_PROD;
                c.mul_go = 1'b1; c.a_src = SRC_TAU; c.b_src = SRC_ERR;
              end
              5'd11: begin
                c.acc_op = ACC_ADD; c.acc_src = SRC_PROD;
                c.mul_go = 1'b1; c.a_src = SRC_TAU; c.b_src = SRC_ERR1;
              end
              5'd12: begin c.acc_op = ACC_SUB; c.acc_src = SRC_PROD; end
              5'd13: begin c.mul_go = 1'b1; c.a_src = SRC_KD; c.b_src = SRC_ACC; end
              5'd14: begin
                c.sum_op = SUM_ADD; c.mul_go = 1'b1; c.a_src = SRC_KP; c.b_src = SRC_ERR;
              end
              5'd15: begin
                c.sum_op = SUM_ADD; c.mul_go = 1'b1; c.a_src = SRC_KI; c.b_src = SRC_BIGE;
              end
              5'd16: c.sum_op = SUM_ADD;
              default: c.done = 1'b1;
            endcase
          end
          MODE_BWD: begin
            case (pc)
              5'd3: begin c.mul_go = 1'b1; c.a_src = SRC_DT; c.b_src = SRC_ERR; end
              5'd4: begin
                c.acc_op = ACC_LD; c.acc_src = SRC_PROD;
                c.mul_go = 1'b1; c.a_src = SRC_DT; c.b_src = SRC_TAU;
              end
              5'd5: begin c.acc_op = ACC_ADD; c.acc_src = SRC_U1; end
              5'd6: begin c.dst = DST_BIGE; c.acc_op = ACC_LD; c.acc_src = SRC_PROD; end
              5'd7: begin c.acc_op = ACC_ADD; c.acc_src = SRC_ONE; end
              5'd8: begin c.div_go = 1'b1; c.a_src = SRC_KD; c.b_src = SRC_ACC; end
              5'd9: begin c.mul_go = 1'b1; c.a_src = SRC_TAU; c.b_src = SRC_ERR; end
              5'd10: begin
                c.acc_op = ACC_LD; c.acc_src = SRC_PROD;
                c.mul_go = 1'b1; c.a_src = SRC_TAU; c.b_src = SRC_ERR1;
              end
              5'd11: begin c.acc_op = ACC_SUB; c.acc_src = SRC_PROD; end
              5'd12: begin c.acc_op = ACC_ADD; c.acc_src = SRC_U1; end
              5'd13: begin c.mul_go = 1'b1; c.a_src = SRC_QUOT; c.b_src = SRC_ACC; end
              5'd14: begin
                c.sum_op = SUM_ADD; c.mul_go = 1'b1; c.a_src = SRC_KP; c.b_src = SRC_ERR;
              end
              5'd15: begin
                c.sum_op = SUM_ADD; c.mul_go = 1'b1; c.a_src = SRC_KI; c.b_src = SRC_BIGE;
              end
              5'd16: c.sum_op = SUM_ADD;
              default: c.done = 1'b1;
            endcase
          end
          MODE_TUST: begin
            case (pc)
              5'd3: begin c.acc_op = ACC_LD; c.acc_src = SRC_ERR; end
              5'd4: begin c.acc_op = ACC_ADD; c.acc_src = SRC_ERR1; end
              5'd5: begin c.mul_go = 1'b1; c.a_src = SRC_DTH; c.b_src = SRC_ACC; end
              5'd6: begin
                c.acc_op = ACC_LD; c.acc_src = SRC_PROD;
                c.mul_go = 1'b1; c.a_src = SRC_DT; c.b_src = SRC_TAU;
              end
              5'd7: begin c.acc_op = ACC_ADD; c.acc_src = SRC_U1; end
              5'd8: begin c.dst = DST_BIGE; c.acc_op = ACC_LD; c.acc_src = SRC_PROD; end
              5'd9: begin c.dst = DST_DTT; c.acc_op = ACC_ADD; c.acc_src = SRC_TWO; end
              5'd10: begin
                c.dst = DST_DEN; c.mul_go = 1'b1; c.a_src = SRC_KD2; c.b_src = SRC_TAU;
              end
              5'd11: begin c.div_go = 1'b1; c.a_src = SRC_PROD; c.b_src = SRC_DEN; end
              5'd12: begin c.acc_op = ACC_LD; c.acc_src = SRC_ERR; end
              5'd13: begin c.acc_op = ACC_SUB; c.acc_src = SRC_ERR1; end
              5'd14: begin
                c.mul_go = 1'b1; c.a_src = SRC_QUOT; c.b_src = SRC_ACC;
                c.acc_op = ACC_LD; c.acc_src = SRC_DTT;
              end
              5'd15: begin c.sum_op = SUM_ADD; c.acc_op = ACC_SUB; c.acc_src = SRC_TWO; end
              5'd16: begin c.div_go = 1'b1; c.a_src = SRC_ACC; c.b_src = SRC_DEN; end
              5'd17: begin c.mul_go = 1'b1; c.a_src = SRC_QUOT; c.b_src = SRC_U1; end
              5'd18: begin
                c.sum_op = SUM_SUB; c.mul_go = 1'b1; c.a_src = SRC_KP; c.b_src = SRC_ERR;
              end
              5'd19: begin
                c.sum_op = SUM_ADD; c.mul_go = 1'b1; c.a_src = SRC_KI; c.b_src = SRC_BIGE;
              end
              5'd20: c.sum_op = SUM_ADD;
              default: c.done = 1'b1;
            endcase
          end
          default: c.done = 1'b1;  // zero drive: the sum was cleared
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/pid_div.sv]
// Radix-2 restoring divider for Q16.16 quotients, (a << 16) / b, saturated.
// Uses pid_pkg; instantiated by pid_dp.
module pid_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [31:0]          a,
  input  logic signed [31:0]          b,
  output logic                        done,
  output logic signed [31:0]          quot
);
  import pid_pkg::*;

  localparam int NumW = 48;

  logic              busy_r, fin_r;
  logic [5:0]        cnt_r;
  logic [NumW-1:0]   num_r, q_r;
  logic [31:0]       rem_r, bmag_r;
  logic              neg_r, bz_r, apos_r, aneg_r;
  logic [32:0]       trial;
  logic [31:0]       amag;

  assign amag  = a[31] ? (~a + 32'd1) : a;
  assign trial = {rem_r, num_r[NumW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(NumW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= {amag, 16'd0};
      bmag_r <= b[31] ? (~b + 32'd1) : b;
      rem_r  <= '0;
      q_r    <= '0;
      neg_r  <= a[31] ^ b[31];
      bz_r   <= (b == '0);
      aneg_r <= a[31];
      apos_r <= !a[31] && (a != '0);
    end else if (busy_r) begin
      num_r <= {num_r[NumW-2:0], 1'b0};
      if (trial >= {1'b0, bmag_r}) begin
        rem_r <= 32'(trial - {1'b0, bmag_r});
        q_r   <= {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[NumW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (bz_r) begin
      quot = apos_r ? S32_MAX : (aneg_r ? S32_MIN : '0);
    end else if (!neg_r) begin
      quot = (q_r > 48'h0000_7FFF_FFFF) ? S32_MAX : q_r[31:0];
    end else begin
      quot = (q_r > 48'h0000_8000_0000) ? S32_MIN : (~q_r[31:0] + 32'd1);
    end
  end

  assign done = fin_r;

endmodule

[hw/rtl/pid_ctrl.sv]
// Sequencer of the PID controller: steps the program, waits on the divider,
// and owns the input and result handshakes. Uses pid_pkg.
module pid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pid_pkg::dp_stat_t stat,
  output pid_pkg::dp_cmd_t  cmd
);
  import pid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [PcW-1:0] pc_r, pc_nxt;
  logic           out_valid_r, out_valid_nxt;
  ucmd_t          step;
  logic           slot_free, commit;

  assign step      = ucode(stat.mode, pc_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    cmd.load_in = 1'b0;
    cmd.op      = UCMD_NOP;
    commit      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_nxt      = '0;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        if (step.done) begin
          // hold until the result register can take the new drive
          if (slot_free) begin
            cmd.op    = step;
            commit    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op = step;
          if (step.div_go) state_nxt = S_DIV;
          else pc_nxt = pc_r + 5'd1;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          pc_nxt    = pc_r + 5'd1;
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/pid_dp.sv]
// Datapath of the PID controller: settings, sample and state registers,
// shared multiplier, accumulators and the divider. Uses pid_pkg, pid_div.
module pid_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [pid_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic signed [31:0]         in_reference,
  input  logic signed [31:0]         in_measured,
  output logic signed [31:0]         out_drive,
  input  pid_pkg::dp_cmd_t           cmd,
  output pid_pkg::dp_stat_t          stat
);
  import pid_pkg::*;

  logic signed [31:0] kp_r, ki_r, kd_r, lo_r, hi_r;
  logic [2:0]         mode_r;
  logic [30:0]        dt_r, tau_r;

  logic signed [31:0] ref_r, meas_r, err_r, e1_r, drive_r, bige_r, den_r, dtt_r;
  logic signed [63:0] prod_r;
  logic signed [AccW-1:0] acc_r, sum_r;

  logic signed [31:0] prodq, accq, kd2, quot, a_val, b_val, acc_val, clamped;
  logic               div_done;
  logic signed [32:0] kd_x2;

  assign prodq = sat48(prod_r[63:16]);
  assign accq  = sat36(acc_r);
  assign kd_x2 = {kd_r, 1'b0};
  assign kd2   = (kd_x2[32] != kd_x2[31]) ? (kd_x2[32] ? S32_MIN : S32_MAX) : kd_x2[31:0];

  function automatic logic signed [31:0] opnd(input src_t s);
    case (s)
      SRC_REF:  return ref_r;
      SRC_MEAS: return meas_r;
      SRC_ERR:  return err_r;
      SRC_ERR1: return e1_r;
      SRC_U1:   return drive_r;
      SRC_DT:   return {1'b0, dt_r};
      SRC_DTH:  return {2'b00, dt_r[30:1]};
      SRC_TAU:  return {1'b0, tau_r};
      SRC_KP:   return kp_r;
      SRC_KI:   return ki_r;
      SRC_KD:   return kd_r;
      SRC_KD2:  return kd2;
      SRC_BIGE: return bige_r;
      SRC_ONE:  return Q_ONE;
      SRC_TWO:  return Q_TWO;
      SRC_PROD: return prodq;
      SRC_ACC:  return accq;
      SRC_QUOT: return quot;
      SRC_DEN:  return den_r;
      SRC_DTT:  return dtt_r;
      default:  return '0;
    endcase
  endfunction

  always_comb begin
    a_val   = opnd(cmd.op.a_src);
    b_val   = opnd(cmd.op.b_src);
    acc_val = opnd(cmd.op.acc_src);
  end

  // crossed limits: a value below the lower limit gets it, any other gets the upper
  always_comb begin
    if (accq < lo_r)      clamped = lo_r;
    else if (accq > hi_r) clamped = hi_r;
    else                  clamped = accq;
  end

  pid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op.div_go),
    .a     (a_val),
    .b     (b_val),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.div_done = div_done;
  assign stat.mode     = mode_r;
  assign out_drive     = drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      mode_r <= '0;
      dt_r   <= '0;
      tau_r  <= '0;
      lo_r   <= S32_MIN;
      hi_r   <= S32_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KP:   kp_r   <= cfg_data;
        REG_KI:   ki_r   <= cfg_data;
        REG_KD:   kd_r   <= cfg_data;
        REG_MODE: mode_r <= cfg_data[2:0];
        REG_DT:   dt_r   <= cfg_data[30:0];
        REG_TAU:  tau_r  <= cfg_data[30:0];
        REG_LO:   lo_r   <= cfg_data;
        REG_HI:   hi_r   <= cfg_data;
        default: ;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r    <= '0;
      drive_r <= '0;
    end else if (cmd.op.done) begin
      e1_r    <= err_r;
      drive_r <= sat36(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ref_r  <= in_reference;
      meas_r <= in_measured;
    end
    if (cmd.op.mul_go) prod_r <= 64'(a_val) * 64'(b_val);
    case (cmd.op.acc_op)
      ACC_LD:  acc_r <= AccW'(acc_val);
      ACC_ADD: acc_r <= acc_r + AccW'(acc_val);
      ACC_SUB: acc_r <= acc_r - AccW'(acc_val);
      default: ;
    endcase
    case (cmd.op.sum_op)
      SUM_CLR: sum_r <= '0;
      SUM_ADD: sum_r <= sum_r + AccW'(prodq);
      SUM_SUB: sum_r <= sum_r - AccW'(prodq);
      default: ;
    endcase
    case (cmd.op.dst)
      DST_ERR:  err_r  <= accq;
      DST_BIGE: bige_r <= clamped;
      DST_DEN:  den_r  <= accq;
      DST_DTT:  dtt_r  <= accq;
      default: ;
    endcase
  end

endmodule

[hw/rtl/discrete_pid_controller.sv]
// Top level of the discrete PID controller: sequencer plus datapath.
// Uses pid_pkg, pid_ctrl, pid_dp.
//
//  channel  direction  handshake          payload
//  in_      sink       valid / stall      reference, measured (Q16.16)
//  out_     source     valid / stall      drive (Q16.16, saturated)
//  cfg_     sink       valid / ready      index (4 bits), data (32 bits)
//
// One request at a time through a shared 32x32 multiplier and a 1-bit-per-cycle
// divider. The step program has pure, forward Euler, backward Euler and Tustin
// modes; any other mode gives a zero drive.
// A new request is taken as soon as the previous drive sits in the output
// register. Reset is synchronous; settings and state return to their defaults.
// A stalled result holds; the last step waits until the output register frees.
module discrete_pid_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_reference,
  input  logic signed [31:0]          in_measured,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_drive,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pid_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import pid_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pid_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_reference (in_reference),
    .in_measured  (in_measured),
    .out_drive    (out_drive),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

[hw/rtl/pid_chk.sv]
// Port-level checks of the PID controller, bound to the top level.
// Depends only on the top level's ports.
module pid_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted request keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // a new result only comes from work in flight
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request");

endmodule

bind discrete_pid_controller pid_chk u_pid_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
